### hdl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants
// Item layouts, register file layout, mode and message codes for the companion
// link supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

	// modes
	localparam logic [3:0] MODE_BOOT      = 4'd0;
	localparam logic [3:0] MODE_WAIT      = 4'd1;
	localparam logic [3:0] MODE_HANDSHAKE = 4'd2;
	localparam logic [3:0] MODE_IDLE      = 4'd3;
	localparam logic [3:0] MODE_ATTACHED  = 4'd4;
	localparam logic [3:0] MODE_ESCORT    = 4'd5;
	localparam logic [3:0] MODE_INTERACT  = 4'd6;
	localparam logic [3:0] MODE_LOWPWR    = 4'd7;
	localparam logic [3:0] MODE_DOCKED    = 4'd8;
	localparam logic [3:0] MODE_ERROR     = 4'd9;
	localparam logic [3:0] MODE_SLEEP     = 4'd10;

	// received message types
	localparam logic [3:0] MSG_ACK    = 4'd0;
	localparam logic [3:0] MSG_ATTACH = 4'd1;
	localparam logic [3:0] MSG_ESCORT = 4'd2;
	localparam logic [3:0] MSG_DOCK   = 4'd3;
	localparam logic [3:0] MSG_IDLE   = 4'd4;
	localparam logic [3:0] MSG_SERVO  = 4'd5;
	localparam logic [3:0] MSG_SOUND  = 4'd6;
	localparam logic [3:0] MSG_HALT   = 4'd7;
	localparam logic [3:0] MSG_RESET  = 4'd8;

	// payload status
	localparam logic [1:0] PSTAT_OK       = 2'd0;
	localparam logic [1:0] PSTAT_OVERSIZE = 2'd2;

	// item kind
	localparam logic ACT_TICK = 1'b0;

	// commands
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_SERVO = 2'd1;
	localparam logic [1:0] CMD_SOUND = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	// send_mask bits
	localparam int SEND_HELLO     = 0;
	localparam int SEND_READY     = 1;
	localparam int SEND_HEARTBEAT = 2;
	localparam int SEND_LOWBATT   = 3;
	localparam int SEND_LINKERR   = 4;

	// behavior_flags bits
	localparam int FLAG_SLEEP    = 0;
	localparam int FLAG_LOWBATT  = 1;
	localparam int FLAG_ALERT    = 2;
	localparam int FLAG_ATTACHED = 3;
	localparam int FLAG_CONFUSED = 4;

	// status_bits bits
	localparam int ST_BATT_EN  = 0;
	localparam int ST_VALID    = 1;
	localparam int ST_CHARGING = 2;
	localparam int ST_ATTACHED = 3;
	localparam int ST_CONFUSED = 4;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_HELLO_RETRY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_LOST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_REPORT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN        = 3'd5;

	localparam logic [31:0] REJECT_GAP_MS  = 32'd1000;
	localparam logic [7:0]  RECOVER_MARGIN = 8'd5;
	localparam logic [7:0]  CENTER_ANGLE   = 8'd90;
	localparam logic [7:0]  MAX_ANGLE      = 8'd180;

	typedef struct packed {
		logic        action;
		logic [31:0] now_ms;
		logic [3:0]  msg_type;
		logic [1:0]  payload_status;
		logic [31:0] session_in;
		logic [7:0]  left_in;
		logic [7:0]  right_in;
		logic [7:0]  track_in;
		logic [6:0]  battery_pct;
		logic [4:0]  status_bits;
	} evt_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] session_id;
		logic [4:0]  send_mask;
		logic [4:0]  behavior_flags;
		logic        dock_active;
		logic        dock_charging;
		logic [1:0]  command;
		logic [7:0]  left_angle;
		logic [7:0]  right_angle;
		logic [7:0]  track;
		logic        link_allowed;
		logic        reject_report;
	} rsp_t;

	typedef struct packed {
		logic [15:0] hello_retry_ms;
		logic [15:0] heartbeat_ms;
		logic [15:0] link_lost_ms;
		logic [15:0] low_report_ms;
		logic [6:0]  critical_pct;
		logic [6:0]  warn_pct;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] session;
		logic [31:0] hello_time;
		logic [31:0] heartbeat_time;
		logic [31:0] receive_time;
		logic [31:0] low_report_time;
		logic [31:0] reject_time;
	} state_t;

	function automatic logic [7:0] sat_angle(input logic [7:0] a);
		return (a > MAX_ANGLE) ? MAX_ANGLE : a;
	endfunction

	function automatic logic remote_ok(input logic [3:0] mode, input logic [31:0] session);
		return (session != 32'd0) && (mode >= MODE_IDLE) && (mode <= MODE_DOCKED);
	endfunction

endpackage

`default_nettype wire

### hdl/cls_evt_if.sv
// ----------------------------------------------------------------------------
// cls_evt_if: input item channel
// Valid/ready channel carrying one tick or received message.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_evt_if;
	logic          valid;
	logic          ready;
	cls_pkg::evt_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/cls_rsp_if.sv
// ----------------------------------------------------------------------------
// cls_rsp_if: result item channel
// Valid/ready channel carrying one supervisor result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_rsp_if;
	logic          valid;
	logic          ready;
	cls_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/cls_cfg_if.sv
// ----------------------------------------------------------------------------
// cls_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cls_pkg::CFG_IDX_W-1:0]   index;
	logic [cls_pkg::CFG_DATA_W-1:0]  wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/cls_cfg.sv
// ----------------------------------------------------------------------------
// cls_cfg: register file
// Holds the interval and battery threshold registers; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_cfg (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cls_cfg_if.sink        cfg,
	output cls_pkg::cfg_t  regs
);

	cls_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hello_retry_ms <= 16'd1000;
			regs_q.heartbeat_ms   <= 16'd1000;
			regs_q.link_lost_ms   <= 16'd3000;
			regs_q.low_report_ms  <= 16'd10000;
			regs_q.critical_pct   <= 7'd10;
			regs_q.warn_pct       <= 7'd20;
		end else if (cfg.valid) begin
			case (cfg.index)
				cls_pkg::CFG_HELLO_RETRY: regs_q.hello_retry_ms <= cfg.wdata[15:0];
				cls_pkg::CFG_HEARTBEAT:   regs_q.heartbeat_ms   <= cfg.wdata[15:0];
				cls_pkg::CFG_LINK_LOST:   regs_q.link_lost_ms   <= cfg.wdata[15:0];
				cls_pkg::CFG_LOW_REPORT:  regs_q.low_report_ms  <= cfg.wdata[15:0];
				cls_pkg::CFG_CRITICAL:    regs_q.critical_pct   <= cfg.wdata[6:0];
				cls_pkg::CFG_WARN:        regs_q.warn_pct       <= cfg.wdata[6:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/cls_step.sv
// ----------------------------------------------------------------------------
// cls_step: per-item update logic
// Next session state and result for one item, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_step (
	input  wire cls_pkg::state_t st,
	input  wire cls_pkg::cfg_t   cfg,
	input  wire cls_pkg::evt_t   e,
	output cls_pkg::state_t      nxt,
	output cls_pkg::rsp_t        rsp
);

	logic [31:0] d_hello, d_hb, d_rx, d_low, d_rej;
	logic        parsed, batt_ok, ok_pre;
	logic [7:0]  pct8, recover8;

	assign d_hello  = e.now_ms - st.hello_time;
	assign d_hb     = e.now_ms - st.heartbeat_time;
	assign d_rx     = e.now_ms - st.receive_time;
	assign d_low    = e.now_ms - st.low_report_time;
	assign d_rej    = e.now_ms - st.reject_time;
	assign parsed   = (e.payload_status == cls_pkg::PSTAT_OK);
	assign batt_ok  = e.status_bits[cls_pkg::ST_BATT_EN] & e.status_bits[cls_pkg::ST_VALID];
	assign ok_pre   = cls_pkg::remote_ok(st.mode, st.session);
	assign pct8     = {1'b0, e.battery_pct};
	assign recover8 = {1'b0, cfg.warn_pct} + cls_pkg::RECOVER_MARGIN;

	always_comb begin
		nxt = st;
		rsp = '0;
		if (e.action == cls_pkg::ACT_TICK) begin
			if (st.mode == cls_pkg::MODE_WAIT) begin
				if (d_hello >= {16'd0, cfg.hello_retry_ms}) begin
					nxt.hello_time = e.now_ms;
					rsp.send_mask[cls_pkg::SEND_HELLO] = 1'b1;
				end
			end else if (st.mode inside {[cls_pkg::MODE_IDLE:cls_pkg::MODE_DOCKED]}) begin
				if (batt_ok) begin
					if (e.battery_pct > cfg.critical_pct) begin
						if (st.mode == cls_pkg::MODE_LOWPWR && pct8 > recover8)
							nxt.mode = cls_pkg::MODE_IDLE;
					end else if (d_low >= {16'd0, cfg.low_report_ms}) begin
						nxt.low_report_time = e.now_ms;
						rsp.send_mask[cls_pkg::SEND_LOWBATT] = 1'b1;
						nxt.mode = cls_pkg::MODE_LOWPWR;
					end
				end
				if (d_hb >= {16'd0, cfg.heartbeat_ms}) begin
					nxt.heartbeat_time = e.now_ms;
					rsp.send_mask[cls_pkg::SEND_HEARTBEAT] = 1'b1;
				end
				// silence check uses the mode after the battery update
				if (st.mode != cls_pkg::MODE_LOWPWR &&
				    (nxt.mode == cls_pkg::MODE_ESCORT || nxt.mode == cls_pkg::MODE_INTERACT) &&
				    d_rx > {16'd0, cfg.link_lost_ms}) begin
					rsp.send_mask[cls_pkg::SEND_LINKERR] = 1'b1;
					nxt.mode       = cls_pkg::MODE_WAIT;
					nxt.session    = '0;
					nxt.hello_time = '0;
				end
			end
		end else begin
			nxt.receive_time = e.now_ms;
			if (e.payload_status != cls_pkg::PSTAT_OVERSIZE) begin
				case (e.msg_type)
					cls_pkg::MSG_ACK: begin
						if (parsed) begin
							nxt.session = e.session_in;
							nxt.mode    = cls_pkg::MODE_IDLE;
							rsp.send_mask[cls_pkg::SEND_READY] = 1'b1;
						end
					end
					cls_pkg::MSG_ATTACH: if (st.session != '0) nxt.mode = cls_pkg::MODE_ATTACHED;
					cls_pkg::MSG_ESCORT: if (st.session != '0) nxt.mode = cls_pkg::MODE_ESCORT;
					cls_pkg::MSG_DOCK:   if (st.session != '0) nxt.mode = cls_pkg::MODE_DOCKED;
					cls_pkg::MSG_IDLE:   if (st.session != '0) nxt.mode = cls_pkg::MODE_IDLE;
					cls_pkg::MSG_SERVO, cls_pkg::MSG_SOUND, cls_pkg::MSG_HALT: begin
						if (!ok_pre) begin
							if (d_rej > cls_pkg::REJECT_GAP_MS) begin
								nxt.reject_time   = e.now_ms;
								rsp.reject_report = 1'b1;
							end
						end else if (e.msg_type == cls_pkg::MSG_HALT) begin
							rsp.command     = cls_pkg::CMD_STOP;
							rsp.left_angle  = cls_pkg::CENTER_ANGLE;
							rsp.right_angle = cls_pkg::CENTER_ANGLE;
						end else if (parsed) begin
							if (e.msg_type == cls_pkg::MSG_SERVO) begin
								rsp.command     = cls_pkg::CMD_SERVO;
								rsp.left_angle  = cls_pkg::sat_angle(e.left_in);
								rsp.right_angle = cls_pkg::sat_angle(e.right_in);
							end else begin
								rsp.command = cls_pkg::CMD_SOUND;
								rsp.track   = e.track_in;
							end
						end
					end
					cls_pkg::MSG_RESET: begin
						nxt.mode           = cls_pkg::MODE_WAIT;
						nxt.session        = '0;
						nxt.hello_time     = '0;
						nxt.heartbeat_time = '0;
					end
					default: ;
				endcase
			end
		end

		rsp.mode       = nxt.mode;
		rsp.session_id = nxt.session;
		rsp.behavior_flags[cls_pkg::FLAG_SLEEP]    = (nxt.mode == cls_pkg::MODE_SLEEP);
		rsp.behavior_flags[cls_pkg::FLAG_LOWBATT]  = (nxt.mode == cls_pkg::MODE_LOWPWR);
		rsp.behavior_flags[cls_pkg::FLAG_ALERT]    = (nxt.mode == cls_pkg::MODE_ESCORT) ||
		                                             (nxt.mode == cls_pkg::MODE_INTERACT);
		rsp.behavior_flags[cls_pkg::FLAG_ATTACHED] = e.status_bits[cls_pkg::ST_ATTACHED];
		rsp.behavior_flags[cls_pkg::FLAG_CONFUSED] = e.status_bits[cls_pkg::ST_CONFUSED];
		rsp.dock_active   = (nxt.mode == cls_pkg::MODE_DOCKED);
		rsp.dock_charging = e.status_bits[cls_pkg::ST_VALID] & e.status_bits[cls_pkg::ST_CHARGING];
		rsp.link_allowed  = cls_pkg::remote_ok(nxt.mode, nxt.session);
	end

endmodule

`default_nettype wire

### hdl/companion_link_supervisor.sv
// ----------------------------------------------------------------------------
// companion_link_supervisor: session supervisor for a serial companion link
// Input register, combinational state update, output register.
// ----------------------------------------------------------------------------
// Each item on evt is a periodic tick or one decoded received message with a
// wrapping millisecond timestamp; each gives exactly one item on rsp, in order.
// An item is captured in an input register; when it moves on, the update logic's
// new mode, session and event times are written into the supervisor state
// together with the result register. One item is taken every cycle while the
// result register is free or being taken: the state update is a single pass of
// compares and muxes, so the next item sees the updated state straight away. A
// result not yet taken holds the result register; the input register still takes
// one more item, and evt.ready drops only while both are full. Registers are
// written on cfg at any time (cfg.ready is always high) and should only be
// changed while the block is idle. Reset leaves the mode at wait-attach with no
// session and all times zero.
// ----------------------------------------------------------------------------
`default_nettype none

module companion_link_supervisor (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cls_evt_if.sink     evt,
	cls_rsp_if.source   rsp,
	cls_cfg_if.sink     cfg
);

	cls_pkg::cfg_t   regs;
	cls_pkg::state_t st_q, st_nxt;
	cls_pkg::evt_t   evt_s1;
	logic            vld_s1;
	cls_pkg::rsp_t   rsp_nxt, rsp_s2;
	logic            vld_s2;
	logic            advance;

	// item in stage 1 moves on when the result register is free or being taken
	assign advance   = vld_s1 & (~vld_s2 | rsp.ready);
	assign evt.ready = ~vld_s1 | advance;
	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

	cls_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cls_step u_step (
		.st  (st_q),
		.cfg (regs),
		.e   (evt_s1),
		.nxt (st_nxt),
		.rsp (rsp_nxt)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (evt.valid && evt.ready)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (advance)
				vld_s2 <= 1'b1;
			else if (rsp.ready)
				vld_s2 <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready)
			evt_s1 <= evt.data;
		if (advance)
			rsp_s2 <= rsp_nxt;
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: cls_pkg::MODE_WAIT, default: '0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

endmodule

`default_nettype wire

### hdl/cls_checker.sv
// ----------------------------------------------------------------------------
// cls_checker: port-level checks
// Result channel holding and consistency of session gating in results.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire cls_pkg::rsp_t rsp_data
);

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// traffic allowed only with a session
	a_link_session: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.link_allowed |-> rsp_data.session_id != 32'd0)
		else $error("link allowed without session");

	// commands never change state, so a passed command leaves the link allowed
	a_cmd_gated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.command != cls_pkg::CMD_NONE |->
			rsp_data.link_allowed && !rsp_data.reject_report)
		else $error("command issued without link");

	// ready goes out only with an ack, which lands in idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.send_mask[cls_pkg::SEND_READY] |->
			rsp_data.mode == cls_pkg::MODE_IDLE)
		else $error("ready sent outside idle");

endmodule

bind companion_link_supervisor cls_checker u_cls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
